### design/max_subarray_sum_with_bounds_core_defines.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef MAX_SUBARRAY_SUM_WITH_BOUNDS_CORE_DEFINES_SVH
`define MAX_SUBARRAY_SUM_WITH_BOUNDS_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MSSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define MSSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mssb_pkg.sv
package mssb_pkg;

   localparam int SUM_W   = 31;
   localparam int INDEX_W = 16;
   localparam int WIDE_W  = 34;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic [SUM_W-1:0]   best_sum;
      logic [INDEX_W-1:0] begin_index;
      logic [INDEX_W-1:0] end_index;
      logic               empty_res;
      logic               length_overflow;
   } result_type;

endpackage

### design/mssb_step.sv
module mssb_step #(
   parameter int MAX_LEN     = 65536,
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_W       = 16,
   parameter int POS_W       = 17
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          last,
   input  logic [mssb_pkg::SUM_W-1:0]    run_sum,
   input  logic [mssb_pkg::SUM_W-1:0]    best_total,
   input  logic [POS_W-1:0]              position,
   input  logic [IDX_W-1:0]              run_start,
   input  logic [IDX_W-1:0]              best_begin,
   input  logic [IDX_W-1:0]              best_end,
   input  logic                          seen_nonneg,
   input  logic                          overflowed,
   output logic [mssb_pkg::SUM_W-1:0]    run_sum_in,
   output logic [mssb_pkg::SUM_W-1:0]    best_total_in,
   output logic [POS_W-1:0]              position_in,
   output logic [IDX_W-1:0]              run_start_in,
   output logic [IDX_W-1:0]              best_begin_in,
   output logic [IDX_W-1:0]              best_end_in,
   output logic                          seen_nonneg_in,
   output logic                          overflowed_in,
   output mssb_pkg::result_type          result
);
   import mssb_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LEN - 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

   logic                     too_long;
   logic [IDX_W-1:0]         idx;
   logic signed [WIDE_W-1:0] sum_wide;
   logic [SUM_W-1:0]         sum_sat;
   logic                     sum_neg;
   logic                     take_best;
   logic [SUM_W-1:0]         new_run;
   logic [SUM_W-1:0]         new_best;
   logic [IDX_W-1:0]         new_start;
   logic [IDX_W-1:0]         new_begin;
   logic [IDX_W-1:0]         new_end;
   logic                     new_seen;
   logic                     new_ovf;

   always_comb begin
      too_long = (position >= POS_LIMIT);
      idx      = too_long ? LAST_IDX : position[IDX_W-1:0];

      sum_wide = $signed({{(WIDE_W - SUM_W){1'b0}}, run_sum})
               + $signed({{(WIDE_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample});
      sum_neg  = sum_wide[WIDE_W-1];
      if (sum_wide > $signed({{(WIDE_W - SUM_W){1'b0}}, SUM_MAX})) begin
         sum_sat = SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end

      new_run   = run_sum;
      new_best  = best_total;
      new_start = run_start;
      new_begin = best_begin;
      new_end   = best_end;
      new_seen  = seen_nonneg;
      new_ovf   = overflowed | too_long;
      take_best = 1'b0;

      if (sum_neg) begin
         // The run ends here; the next one starts after this element.
         new_run   = '0;
         new_start = (idx == LAST_IDX) ? LAST_IDX : idx + 1'b1;
      end else begin
         new_run   = sum_sat;
         take_best = (sum_sat > best_total) || !seen_nonneg;
         if (take_best) begin
            if (sum_sat > best_total) begin
               new_best = sum_sat;
            end
            new_begin = run_start;
            new_end   = idx;
         end
         new_seen = 1'b1;
      end

      result.best_sum        = new_best;
      result.begin_index     = new_seen ? INDEX_W'(new_begin) : '0;
      result.end_index       = new_seen ? INDEX_W'(new_end) : '0;
      result.empty_res       = !new_seen;
      result.length_overflow = new_ovf;

      if (last) begin
         run_sum_in     = '0;
         best_total_in  = '0;
         position_in    = '0;
         run_start_in   = '0;
         best_begin_in  = '0;
         best_end_in    = '0;
         seen_nonneg_in = 1'b0;
         overflowed_in  = 1'b0;
      end else begin
         run_sum_in     = new_run;
         best_total_in  = new_best;
         position_in    = too_long ? position : position + 1'b1;
         run_start_in   = new_start;
         best_begin_in  = new_begin;
         best_end_in    = new_end;
         seen_nonneg_in = new_seen;
         overflowed_in  = new_ovf;
      end
   end

endmodule

### design/mssb_result_reg.sv
module mssb_result_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mssb_pkg::result_type load_data,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mssb_pkg::result_type rsp_data
);
   import mssb_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### design/max_subarray_sum_with_bounds_core.sv
// Channel   Ports                                       Handshake
// req       req_sample, req_last                        req_valid / req_stall
// rsp       rsp_best_sum, rsp_begin_index, rsp_end_index,
//           rsp_empty_res, rsp_length_overflow          rsp_valid / rsp_stall
//
// One item per cycle is accepted while req_stall is low; each item is held
// in the input register, and the sum, clamp and compare update happens
// on leaving it, when a last item also moves into the result register.
// Synchronous active-high reset empties both registers and clears the state.
// Only a last item waits on a stalled, full result register; others pass.
`include "max_subarray_sum_with_bounds_core_defines.svh"

module max_subarray_sum_with_bounds_core #(
   parameter int MAX_LEN     = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mssb_pkg::SUM_W-1:0]         rsp_best_sum,
   output logic [mssb_pkg::INDEX_W-1:0]       rsp_begin_index,
   output logic [mssb_pkg::INDEX_W-1:0]       rsp_end_index,
   output logic                               rsp_empty_res,
   output logic                               rsp_length_overflow
);
   import mssb_pkg::*;

   localparam int IDX_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
   localparam int POS_W = $clog2(MAX_LEN + 1);

   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_last_ff;
   logic                          s1_move;
   logic                          req_take;
   logic                          out_free;

   logic [SUM_W-1:0] run_ff, run_in;
   logic [SUM_W-1:0] best_ff, best_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] begin_ff, begin_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic             seen_ff, seen_in;
   logic             ovf_ff, ovf_in;

   result_type step_result;
   result_type rsp_data;

   assign s1_move   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take || (s1_valid_ff && !s1_move);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_last;
      end
   end

   mssb_step #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .POS_W       (POS_W)
   ) u_step (
      .sample         (s1_sample_ff),
      .last           (s1_last_ff),
      .run_sum        (run_ff),
      .best_total     (best_ff),
      .position       (pos_ff),
      .run_start      (start_ff),
      .best_begin     (begin_ff),
      .best_end       (end_ff),
      .seen_nonneg    (seen_ff),
      .overflowed     (ovf_ff),
      .run_sum_in     (run_in),
      .best_total_in  (best_in),
      .position_in    (pos_in),
      .run_start_in   (start_in),
      .best_begin_in  (begin_in),
      .best_end_in    (end_in),
      .seen_nonneg_in (seen_in),
      .overflowed_in  (ovf_in),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         best_ff  <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         begin_ff <= '0;
         end_ff   <= '0;
         seen_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (s1_move) begin
         run_ff   <= run_in;
         best_ff  <= best_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         begin_ff <= begin_in;
         end_ff   <= end_in;
         seen_ff  <= seen_in;
         ovf_ff   <= ovf_in;
      end
   end

   mssb_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_move && s1_last_ff),
      .load_data (step_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_best_sum        = rsp_data.best_sum;
   assign rsp_begin_index     = rsp_data.begin_index;
   assign rsp_end_index       = rsp_data.end_index;
   assign rsp_empty_res       = rsp_data.empty_res;
   assign rsp_length_overflow = rsp_data.length_overflow;

   `MSSB_ASSERT(a_pos_bound, clock, reset, pos_ff <= POS_W'(MAX_LEN), "position past limit")
   `MSSB_ASSERT(a_run_le_best, clock, reset, run_ff <= best_ff, "running sum above best sum")
   `MSSB_ASSERT_NEXT(a_clear_after_last, clock, reset, s1_move && s1_last_ff, pos_ff == '0 && !seen_ff && !ovf_ff, "state not cleared after last item")
   `MSSB_ASSERT(a_empty_zero, clock, reset, !rsp_valid || !rsp_empty_res || (rsp_best_sum == '0 && rsp_begin_index == '0 && rsp_end_index == '0), "empty result with nonzero fields")

endmodule

### tb/tb_max_subarray_sum_with_bounds_core.sv
module tb_max_subarray_sum_with_bounds_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mssb_pkg::*;

   localparam int MAX_LEN      = 65536;
   localparam int SAMPLE_BITS  = 16;
   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 250;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [SUM_W-1:0]              rsp_best_sum;
   logic [INDEX_W-1:0]            rsp_begin_index;
   logic [INDEX_W-1:0]            rsp_end_index;
   logic                          rsp_empty_res;
   logic                          rsp_length_overflow;

   max_subarray_sum_with_bounds_core #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_best_sum        (rsp_best_sum),
      .rsp_begin_index     (rsp_begin_index),
      .rsp_end_index       (rsp_end_index),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_length_overflow (rsp_length_overflow)
   );

   always #CLOCK_HALF clock = ~clock;

   // Predicted state of the sequence in progress.
   logic [SUM_W-1:0]   run_total;
   logic [SUM_W-1:0]   best_total;
   int unsigned        seq_position;
   logic [INDEX_W-1:0] run_first;
   logic [INDEX_W-1:0] best_first;
   logic [INDEX_W-1:0] best_last;
   logic               seen_nonneg;
   logic               seq_overflowed;

   result_type sums_due[$];
   result_type seen_result;
   int         mismatch_count = 0;
   int         gap_max = 19;
   int         stall_max = 19;
   int         stall_left = 0;
   int         hold_off_cycles = 0;
   int         cycle_count;

   task automatic clear_sequence();
      run_total      = '0;
      best_total     = '0;
      seq_position   = 0;
      run_first      = '0;
      best_first     = '0;
      best_last      = '0;
      seen_nonneg    = 1'b0;
      seq_overflowed = 1'b0;
   endtask

   task automatic kadane_update(input logic signed [SAMPLE_BITS-1:0] s, input logic is_last);
      int unsigned idx;
      longint      trial;
      result_type  res;
      if (seq_position >= MAX_LEN) begin
         seq_overflowed = 1'b1;
         idx = MAX_LEN - 1;
      end else begin
         idx = seq_position;
         seq_position++;
      end
      trial = longint'(run_total) + longint'(s);
      if (trial > longint'(SUM_MAX))
         trial = longint'(SUM_MAX);
      if (trial < 0) begin
         run_total = '0;
         run_first = INDEX_W'((idx + 1 < MAX_LEN) ? idx + 1 : MAX_LEN - 1);
      end else begin
         run_total = trial[SUM_W-1:0];
         // The first nonnegative sum claims the bounds even when it is zero.
         if (trial > longint'(best_total) || !seen_nonneg) begin
            if (trial > longint'(best_total))
               best_total = trial[SUM_W-1:0];
            best_first = run_first;
            best_last  = INDEX_W'(idx);
         end
         seen_nonneg = 1'b1;
      end
      if (is_last) begin
         res.best_sum        = best_total;
         res.begin_index     = seen_nonneg ? best_first : '0;
         res.end_index       = seen_nonneg ? best_last : '0;
         res.empty_res       = !seen_nonneg;
         res.length_overflow = seq_overflowed;
         sums_due = {sums_due, res};
         clear_sequence();
      end
   endtask

   // Called just after a rising edge; returns just after the edge that accepts the item.
   task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic is_last);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= is_last;
      do @(posedge clock); while (req_stall);
      kadane_update(s, is_last);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_directed();
      gap_max   = 19;
      stall_max = 19;
      offer_sample(16'sh7FFF, 1'b1);
      offer_sample(-16'sh8000, 1'b1);
      offer_sample(16'sd0, 1'b1);
      // Every element negative: empty result.
      offer_sample(-16'sd5, 1'b0);
      offer_sample(-16'sd3, 1'b0);
      offer_sample(-16'sd1, 1'b1);
      // Zero maximum: bounds name the first element where the sum reached zero.
      offer_sample(-16'sd2, 1'b0);
      offer_sample(16'sd0, 1'b0);
      offer_sample(-16'sd1, 1'b0);
      offer_sample(16'sd0, 1'b1);
      // A run summing to zero continues; an equal sum later keeps the earliest end.
      offer_sample(16'sd4, 1'b0);
      offer_sample(-16'sd4, 1'b0);
      offer_sample(16'sd4, 1'b0);
      offer_sample(16'sd1, 1'b1);
      offer_sample(16'sd5, 1'b0);
      offer_sample(-16'sd6, 1'b0);
      offer_sample(16'sd2, 1'b0);
      offer_sample(16'sd3, 1'b1);
      offer_sample(-16'sh8000, 1'b0);
      offer_sample(16'sh7FFF, 1'b0);
      offer_sample(16'sh7FFF, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_sequences();
      int                            sent;
      int                            seq_len;
      int                            mode;
      logic signed [SAMPLE_BITS-1:0] v;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seq_len   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
         mode      = $urandom_range(0, 3);
         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 19;
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
         for (int i = 0; i < seq_len; i++) begin
            case (mode)
               0: v = SAMPLE_BITS'($urandom_range(0, 65535));
               1: v = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
               2: begin
                  if ($urandom_range(0, 4) == 0)
                     v = SAMPLE_BITS'($urandom_range(0, 200));
                  else
                     v = SAMPLE_BITS'(-int'($urandom_range(1, 200)));
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: v = -16'sh8000;
                     1: v = 16'sh7FFF;
                     2: v = 16'sd0;
                     3: v = -16'sd1;
                     default: v = 16'sd1;
                  endcase
               end
            endcase
            offer_sample(v, i == seq_len - 1);
         end
         sent += seq_len;
         if ($urandom_range(0, 15) == 0)
            wait_for_results();
      end
      wait_for_results();
   endtask

   // The receiver holds off while short sequences keep coming, so the block fills up.
   task automatic test_backpressure();
      gap_max   = 0;
      stall_max = 0;
      hold_off_cycles <= 300;
      for (int i = 0; i < 60; i++)
         offer_sample(SAMPLE_BITS'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      offer_sample(SAMPLE_BITS'($urandom_range(0, 65535)), 1'b1);
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         stall_left = $urandom_range(0, stall_max);
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sums_due.size() == 0) begin
            $error("result item arrived with none expected");
            mismatch_count++;
         end else begin
            seen_result = sums_due.pop_front();
            if (rsp_best_sum !== seen_result.best_sum) begin
               $error("best_sum: expected %0d, actual %0d", seen_result.best_sum, rsp_best_sum);
               mismatch_count++;
            end
            if (rsp_begin_index !== seen_result.begin_index) begin
               $error("begin_index: expected %0d, actual %0d",
                      seen_result.begin_index, rsp_begin_index);
               mismatch_count++;
            end
            if (rsp_end_index !== seen_result.end_index) begin
               $error("end_index: expected %0d, actual %0d",
                      seen_result.end_index, rsp_end_index);
               mismatch_count++;
            end
            if (rsp_empty_res !== seen_result.empty_res) begin
               $error("empty_res: expected %0d, actual %0d",
                      seen_result.empty_res, rsp_empty_res);
               mismatch_count++;
            end
            if (rsp_length_overflow !== seen_result.length_overflow) begin
               $error("length_overflow: expected %0d, actual %0d",
                      seen_result.length_overflow, rsp_length_overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      clear_sequence();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sequences();
      test_backpressure();
      test_random_sequences();
      wait_for_results();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
